### hw/rtl/i2c_master_register_access_core_macros.svh
// Assertion macros for the I2C register access RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("I2C register access assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("I2C register access assertion failed");

`endif

### hw/rtl/i2cra_pkg.sv
// Types shared by the I2C register access core and its channel interfaces.
// No dependencies.
package i2cra_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_DATA  = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } req_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       data_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
  } rsp_item_t;

endpackage

### hw/rtl/i2cra_if.sv
// Valid/ready channel interfaces for the I2C register access core.
// Depends on i2cra_pkg for the item types.
interface i2cra_req_if;
  logic                  valid;
  logic                  ready;
  i2cra_pkg::req_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface i2cra_rsp_if;
  logic                  valid;
  logic                  ready;
  i2cra_pkg::rsp_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/i2c_master_register_access_core.sv
// I2C master register access sequencer, top level.
// Depends on i2cra_pkg, the channel interfaces in i2cra_if.sv and the assertion macros.
//
// Usage: every request item on req_i yields exactly one result item on rsp_o. A tick item
// advances the bus sequence by one half-bit phase; the result carries the SCL and SDA levels
// to drive for that phase. A begin-write or begin-read item starts a transaction when the
// block is idle and is ignored otherwise. During a write the block raises data_request and
// waits for a supply item carrying the next byte. During a read each completed byte is
// reported once with read_valid, and the final byte of the transaction also with read_last.
// The slave's acknowledge is clocked but not checked.
// Latency: the result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle. All of the sequencing is a short block of logic between
// the state registers and a single result register, so a new item is taken whenever the
// result register is empty or its item is being taken in the same cycle.
// Stalls: when the receiver holds rsp_o.ready low the pending result is held and req_i.ready
// drops until it has gone; the sequencer state does not move meanwhile.
// Reset: asynchronous and active low; both bus lines come up released, the sequencer idle
// and the result register empty.
module i2c_master_register_access_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cra_req_if.sink         req_i,
  i2cra_rsp_if.source       rsp_o
);
  import i2cra_pkg::*;

  `include "i2c_master_register_access_core_macros.svh"

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_SETUP  = 5'd1,
    PH_ST1    = 5'd2,
    PH_ST2    = 5'd3,
    PH_DEV_LO = 5'd4,
    PH_DEV_HI = 5'd5,
    PH_REG_LO = 5'd6,
    PH_REG_HI = 5'd7,
    PH_WAIT   = 5'd8,
    PH_DAT_LO = 5'd9,
    PH_DAT_HI = 5'd10,
    PH_RS1    = 5'd11,
    PH_RS2    = 5'd12,
    PH_RS3    = 5'd13,
    PH_RS4    = 5'd14,
    PH_RA_LO  = 5'd15,
    PH_RA_HI  = 5'd16,
    PH_RD_LO  = 5'd17,
    PH_RD_HI  = 5'd18,
    PH_AK_LO  = 5'd19,
    PH_AK_HI  = 5'd20,
    PH_P1     = 5'd21,
    PH_P2     = 5'd22,
    PH_P3     = 5'd23
  } phase_e;

  // Eight data slots plus the acknowledge slot per transmitted byte.
  localparam logic [3:0] TxSlots  = 4'd9;
  localparam logic [3:0] ReadBits = 4'd8;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] dev_q, dev_d;
  logic [7:0] reg_q, reg_d;
  logic       rmode_q, rmode_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  rsp_item_t  out_q, out_d;
  logic       out_valid_q;
  logic       accept;

  // Helper values used by several phases.
  logic [3:0] bit_inc;
  logic [7:0] left_dec;
  logic [7:0] rx_shift;
  logic [7:0] tx_shift;
  logic       tx_more;
  logic [7:0] rd_data;
  logic       rd_valid;
  logic       rd_last;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign bit_inc  = bit_q + 4'd1;
  assign left_dec = left_q - 8'd1;
  assign rx_shift = {shift_q[6:0], req_i.item.sda_in};
  assign tx_shift = {shift_q[6:0], 1'b0};
  // The high phase of a transmit slot moves on to the next slot until the acknowledge
  // slot has been clocked.
  assign tx_more  = bit_inc < TxSlots;

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    left_d   = left_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    rmode_d  = rmode_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rd_data  = 8'd0;
    rd_valid = 1'b0;
    rd_last  = 1'b0;

    case (req_i.item.req_type)
      REQ_WRITE, REQ_READ: begin
        if (phase_q == PH_IDLE) begin
          dev_d   = req_i.item.device_addr;
          reg_d   = req_i.item.reg_addr;
          left_d  = req_i.item.byte_count;
          rmode_d = (req_i.item.req_type == REQ_READ);
          phase_d = PH_SETUP;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
      end
      REQ_DATA: begin
        if (phase_q == PH_WAIT) begin
          shift_d = req_i.item.data_byte;
          bit_d   = 4'd0;
          phase_d = PH_DAT_LO;
          scl_d   = 1'b0;
          sda_d   = req_i.item.data_byte[7];
        end
      end
      default: begin
        case (phase_q)
          PH_IDLE, PH_WAIT: begin
          end
          PH_SETUP: begin
            phase_d = PH_ST1;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_ST1: begin
            phase_d = PH_ST2;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
          end
          PH_ST2: begin
            shift_d = dev_q;
            bit_d   = 4'd0;
            phase_d = PH_DEV_LO;
            scl_d   = 1'b0;
            sda_d   = dev_q[7];
          end
          // Low halves of a bit raise SCL and keep SDA as set up.
          PH_DEV_LO, PH_REG_LO, PH_DAT_LO, PH_RA_LO, PH_RD_LO, PH_AK_LO, PH_P1: begin
            phase_d = phase_e'(phase_q + 5'd1);
            scl_d   = 1'b1;
          end
          PH_DEV_HI, PH_REG_HI, PH_DAT_HI, PH_RA_HI: begin
            if (tx_more) begin
              // Next slot: the next data bit, or SDA released for the acknowledge.
              shift_d = tx_shift;
              bit_d   = bit_inc;
              phase_d = phase_e'(phase_q - 5'd1);
              scl_d   = 1'b0;
              sda_d   = (bit_inc < ReadBits) ? shift_q[6] : 1'b1;
            end else begin
              case (phase_q)
                PH_DEV_HI: begin
                  shift_d = reg_q;
                  bit_d   = 4'd0;
                  phase_d = PH_REG_LO;
                  scl_d   = 1'b0;
                  sda_d   = reg_q[7];
                end
                PH_REG_HI: begin
                  scl_d = 1'b0;
                  if (rmode_q) begin
                    phase_d = PH_RS1;
                    sda_d   = 1'b1;
                  end else if (left_q == 8'd0) begin
                    phase_d = PH_P1;
                    sda_d   = 1'b0;
                  end else begin
                    phase_d = PH_WAIT;
                  end
                end
                PH_DAT_HI: begin
                  left_d = left_dec;
                  scl_d  = 1'b0;
                  if (left_dec == 8'd0) begin
                    phase_d = PH_P1;
                    sda_d   = 1'b0;
                  end else begin
                    phase_d = PH_WAIT;
                  end
                end
                default: begin
                  // Read address sent: stop at once or start clocking in data.
                  scl_d = 1'b0;
                  if (left_q == 8'd0) begin
                    phase_d = PH_P1;
                    sda_d   = 1'b0;
                  end else begin
                    shift_d = 8'd0;
                    bit_d   = 4'd0;
                    phase_d = PH_RD_LO;
                    sda_d   = 1'b1;
                  end
                end
              endcase
            end
          end
          PH_RS1: begin
            phase_d = PH_RS2;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_RS2: begin
            phase_d = PH_RS3;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_RS3: begin
            phase_d = PH_RS4;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
          end
          PH_RS4: begin
            shift_d = dev_q + 8'd1;
            bit_d   = 4'd0;
            phase_d = PH_RA_LO;
            scl_d   = 1'b0;
            sda_d   = shift_d[7];
          end
          PH_RD_HI: begin
            shift_d = rx_shift;
            bit_d   = bit_inc;
            scl_d   = 1'b0;
            if (bit_inc < ReadBits) begin
              phase_d = PH_RD_LO;
              sda_d   = 1'b1;
            end else begin
              // Byte complete: report it and acknowledge low unless it is the last.
              rd_data  = rx_shift;
              rd_valid = 1'b1;
              rd_last  = (left_q == 8'd1);
              phase_d  = PH_AK_LO;
              sda_d    = rd_last;
            end
          end
          PH_AK_HI: begin
            left_d = left_dec;
            scl_d  = 1'b0;
            if (left_dec == 8'd0) begin
              phase_d = PH_P1;
              sda_d   = 1'b0;
            end else begin
              shift_d = 8'd0;
              bit_d   = 4'd0;
              phase_d = PH_RD_LO;
              sda_d   = 1'b1;
            end
          end
          PH_P2: begin
            phase_d = PH_P3;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_P3: begin
            phase_d = PH_IDLE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          default: begin
            // Unused phase codes fall back to idle with both lines released.
            phase_d = PH_IDLE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
        endcase
      end
    endcase

    out_d.scl_level    = scl_d;
    out_d.sda_level    = sda_d;
    out_d.busy_res     = (phase_d != PH_IDLE);
    out_d.data_request = (phase_d == PH_WAIT);
    out_d.read_data    = rd_data;
    out_d.read_valid   = rd_valid;
    out_d.read_last    = rd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      left_q      <= 8'd0;
      dev_q       <= 8'd0;
      reg_q       <= 8'd0;
      rmode_q     <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        left_q      <= left_d;
        dev_q       <= dev_d;
        reg_q       <= reg_d;
        rmode_q     <= rmode_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.item  = out_q;

  // A reported read byte always belongs to a transaction still in progress.
  `I2CRA_ASSERT_IMP(a_read_in_txn, out_valid_q && out_q.read_valid, out_q.busy_res)
  // The last-byte mark never appears without a byte.
  `I2CRA_ASSERT_IMP(a_last_has_data, out_valid_q && out_q.read_last, out_q.read_valid)
  // While idle both bus lines are released.
  `I2CRA_ASSERT_IMP(a_idle_released, phase_q == PH_IDLE, scl_q && sda_q)
  // While waiting for a write byte SCL is held low.
  `I2CRA_ASSERT_IMP(a_wait_scl_low, phase_q == PH_WAIT, !scl_q)
  // A begin request taken while idle starts the setup phase.
  `I2CRA_ASSERT_NXT(a_begin_starts,
                    accept && phase_q == PH_IDLE &&
                    (req_i.item.req_type == REQ_WRITE || req_i.item.req_type == REQ_READ),
                    phase_q == PH_SETUP)

endmodule

### tb/sv/i2cra_sequence_model_pkg.sv
`timescale 1ns / 1ps
// Cycle-free model of the I2C register access sequencer with its store of expected results.
// Depends on i2cra_pkg for the request and result item types.
package i2cra_sequence_model_pkg;
  import i2cra_pkg::*;

  // Half-bit phases of the bus sequence, in the order the sequencer walks them.
  typedef enum logic [4:0] {
    PH_IDLE, PH_SETUP, PH_START_A, PH_START_B,
    PH_DEV_LO, PH_DEV_HI, PH_REG_LO, PH_REG_HI,
    PH_WAIT_BYTE, PH_DAT_LO, PH_DAT_HI,
    PH_RSTART_A, PH_RSTART_B, PH_RSTART_C, PH_RSTART_D,
    PH_RADDR_LO, PH_RADDR_HI, PH_RD_LO, PH_RD_HI, PH_ACK_LO, PH_ACK_HI,
    PH_STOP_A, PH_STOP_B, PH_STOP_C
  } bus_phase_e;

  localparam logic [3:0] TX_SLOTS = 4'd9;
  localparam logic [3:0] RX_BITS  = 4'd8;

  class i2c_sequence_model;
    bus_phase_e ph;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic [7:0] left;
    logic [7:0] dev;
    logic [7:0] reg_sub;
    logic       rd_mode;
    logic       scl;
    logic       sda;
    rsp_item_t  expected_lines[$];
    int         mismatches;

    function new();
      ph       = PH_IDLE;
      bit_idx  = '0;
      shreg    = '0;
      left     = '0;
      dev      = '0;
      reg_sub  = '0;
      rd_mode  = 1'b0;
      scl      = 1'b1;
      sda      = 1'b1;
      mismatches = 0;
    endfunction

    function void go(bus_phase_e p, logic c, logic d);
      ph  = p;
      scl = c;
      sda = d;
    endfunction

    function void load_tx(bus_phase_e p, logic [7:0] v);
      shreg   = v;
      bit_idx = '0;
      go(p, 1'b0, v[7]);
    endfunction

    // High half of a transmit slot; true once the acknowledge slot has been clocked.
    function bit tx_slot_done();
      if (bit_idx + 4'd1 < TX_SLOTS) begin
        shreg   = shreg << 1;
        bit_idx = bit_idx + 4'd1;
        go(bus_phase_e'(ph - 5'd1), 1'b0, (bit_idx < RX_BITS) ? shreg[7] : 1'b1);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void after_count();
      if (left == 8'd0) go(PH_STOP_A, 1'b0, 1'b0);
      else go(PH_WAIT_BYTE, 1'b0, sda);
    endfunction

    function void start_rx_byte();
      shreg   = '0;
      bit_idx = '0;
      go(PH_RD_LO, 1'b0, 1'b1);
    endfunction

    // True when the request changes the sequencer state.
    function bit moves_state(req_item_t it);
      case (it.req_type)
        REQ_WRITE, REQ_READ: return ph == PH_IDLE;
        REQ_DATA:            return ph == PH_WAIT_BYTE;
        default:             return ph != PH_IDLE && ph != PH_WAIT_BYTE;
      endcase
    endfunction

    function void take_request(req_item_t it);
      rsp_item_t r;
      r = '0;
      case (it.req_type)
        REQ_WRITE, REQ_READ: begin
          if (ph == PH_IDLE) begin
            dev     = it.device_addr;
            reg_sub = it.reg_addr;
            left    = it.byte_count;
            rd_mode = (it.req_type == REQ_READ);
            go(PH_SETUP, 1'b1, 1'b1);
          end
        end
        REQ_DATA: begin
          if (ph == PH_WAIT_BYTE) load_tx(PH_DAT_LO, it.data_byte);
        end
        default: begin
          case (ph)
            PH_IDLE, PH_WAIT_BYTE: ;
            PH_SETUP:   go(PH_START_A, 1'b1, 1'b0);
            PH_START_A: go(PH_START_B, 1'b0, 1'b0);
            PH_START_B: load_tx(PH_DEV_LO, dev);
            PH_DEV_LO, PH_REG_LO, PH_DAT_LO, PH_RADDR_LO, PH_RD_LO, PH_ACK_LO, PH_STOP_A:
              go(bus_phase_e'(ph + 5'd1), 1'b1, sda);
            PH_DEV_HI: if (tx_slot_done()) load_tx(PH_REG_LO, reg_sub);
            PH_REG_HI: begin
              if (tx_slot_done()) begin
                if (rd_mode) go(PH_RSTART_A, 1'b0, 1'b1);
                else after_count();
              end
            end
            PH_DAT_HI: begin
              if (tx_slot_done()) begin
                left = left - 8'd1;
                after_count();
              end
            end
            PH_RSTART_A: go(PH_RSTART_B, 1'b1, 1'b1);
            PH_RSTART_B: go(PH_RSTART_C, 1'b1, 1'b0);
            PH_RSTART_C: go(PH_RSTART_D, 1'b0, 1'b0);
            PH_RSTART_D: load_tx(PH_RADDR_LO, dev + 8'd1);
            PH_RADDR_HI: begin
              if (tx_slot_done()) begin
                if (left == 8'd0) go(PH_STOP_A, 1'b0, 1'b0);
                else start_rx_byte();
              end
            end
            PH_RD_HI: begin
              shreg   = {shreg[6:0], it.sda_in};
              bit_idx = bit_idx + 4'd1;
              if (bit_idx < RX_BITS) begin
                go(PH_RD_LO, 1'b0, 1'b1);
              end else begin
                r.read_data  = shreg;
                r.read_valid = 1'b1;
                r.read_last  = (left == 8'd1);
                go(PH_ACK_LO, 1'b0, r.read_last);
              end
            end
            PH_ACK_HI: begin
              left = left - 8'd1;
              if (left == 8'd0) go(PH_STOP_A, 1'b0, 1'b0);
              else start_rx_byte();
            end
            PH_STOP_B: go(PH_STOP_C, 1'b1, 1'b1);
            PH_STOP_C: go(PH_IDLE, 1'b1, 1'b1);
            default:   go(PH_IDLE, 1'b1, 1'b1);
          endcase
        end
      endcase
      r.scl_level    = scl;
      r.sda_level    = sda;
      r.busy_res     = (ph != PH_IDLE);
      r.data_request = (ph == PH_WAIT_BYTE);
      expected_lines.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_lines.pop_front();
      check_field("scl_level",    want.scl_level,    got.scl_level);
      check_field("sda_level",    want.sda_level,    got.sda_level);
      check_field("busy_res",     want.busy_res,     got.busy_res);
      check_field("data_request", want.data_request, got.data_request);
      check_field("read_data",    want.read_data,    got.read_data);
      check_field("read_valid",   want.read_valid,   got.read_valid);
      check_field("read_last",    want.read_last,    got.read_last);
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the I2C register access sequencer: stimulus, handshakes and checks.
// Depends on i2cra_pkg, the channel interfaces and i2cra_sequence_model_pkg.
module tb_top;
  import i2cra_pkg::*;
  import i2cra_sequence_model_pkg::*;

  // Roughly a quarter of the useful items go to each idling phase.
  localparam int ITEMS_PER_PHASE = 330;
  // Cycles without any handshake on either side before the run is declared hung.
  localparam int HANG_LIMIT      = 1000;
  // Extra cycles allowed at the end for anything still in flight.
  localparam int DRAIN_CYCLES    = 8;

  logic clk_i;
  logic rst_ni;

  i2cra_req_if req_if ();
  i2cra_rsp_if rsp_if ();

  i2c_master_register_access_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  i2c_sequence_model model;

  int          idle_pct;
  int          stall_pct;
  int          useful_items;
  int          sda_fixed;
  int          quiet_cycles;
  logic [7:0]  write_bytes[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver drops ready at random, at the rate the current phase asks for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every result taken from the block is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      model.check_result(rsp_if.item);
    end
  end

  // The watchdog is reset by any handshake, so a stuck channel ends the run quickly.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_item_t mk(req_type_e kind, logic [7:0] dev, logic [7:0] sub,
                                   logic [7:0] cnt, logic [7:0] dat, logic sda_bit);
    req_item_t it;
    it.req_type    = kind;
    it.device_addr = dev;
    it.reg_addr    = sub;
    it.byte_count  = cnt;
    it.data_byte   = dat;
    it.sda_in      = sda_bit;
    return it;
  endfunction

  // A request whose every field is random, used as noise against the current state.
  function automatic req_item_t noise_item();
    return mk(req_type_e'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom));
  endfunction

  // The slave's answer on SDA: either pinned for a directed case or random.
  function automatic logic slave_bit();
    return (sda_fixed < 0) ? 1'($urandom_range(1)) : 1'(sda_fixed);
  endfunction

  // Presents one item, possibly after some idle cycles, and waits for the block to take it.
  // The item is handed to the model in the step of the accepting edge, so the next choice
  // of stimulus always sees the state that the block will be in.
  task automatic send(req_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.item  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    if (model.moves_state(it)) useful_items++;
    model.take_request(it);
  endtask

  task automatic tick();
    send(mk(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), slave_bit()));
  endtask

  // Runs the current transaction to its stop condition, supplying write bytes on demand.
  task automatic finish_bus();
    logic [7:0] b;
    while (model.ph != PH_IDLE) begin
      if (model.ph == PH_WAIT_BYTE) begin
        b = (write_bytes.size() != 0) ? write_bytes.pop_front() : 8'($urandom);
        send(mk(REQ_DATA, 8'($urandom), 8'($urandom), 8'($urandom), b, 1'($urandom)));
      end else begin
        tick();
      end
    end
  endtask

  task automatic advance_to(bus_phase_e target);
    while (model.ph != target) tick();
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed transactions with random content, with some noise mixed in.
  task automatic random_item();
    int unsigned r;
    int unsigned c;
    logic [7:0]  cnt;
    r = $urandom_range(99);
    c = $urandom_range(99);
    case (model.ph)
      PH_IDLE: begin
        // Most transactions are short; now and then a longer one.
        cnt = (c < 85) ? 8'($urandom_range(3)) :
              (c < 99) ? 8'($urandom_range(12, 4)) : 8'($urandom_range(40, 13));
        if (r < 80) begin
          send(mk((r < 40) ? REQ_WRITE : REQ_READ, 8'($urandom), 8'($urandom), cnt,
                  8'($urandom), 1'($urandom)));
        end else begin
          send(noise_item());
        end
      end
      PH_WAIT_BYTE: begin
        if (r < 85) begin
          send(mk(REQ_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom)));
        end else begin
          send(noise_item());
        end
      end
      default: begin
        if (r < 94) tick();
        else send(noise_item());
      end
    endcase
  endtask

  initial begin
    model        = new();
    idle_pct     = 0;
    stall_pct    = 0;
    useful_items = 0;
    sda_fixed    = -1;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.item  = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A tick and a stray data byte while idle must leave the lines released.
    send(mk(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    send(mk(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'hC3, 1'b0));

    // A write of no bytes stops straight after the register address.
    send(mk(REQ_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0));
    finish_bus();

    // A read of no bytes from the odd address 0xFF: the read address wraps round to zero.
    send(mk(REQ_READ, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
    finish_bus();

    // Two-byte write with the extreme data values. While the block waits for a byte, a tick,
    // a begin request and a stray byte during the transfer must all be ignored.
    write_bytes = '{8'h00};
    send(mk(REQ_WRITE, 8'hA4, 8'h5A, 8'h02, 8'h00, 1'b0));
    advance_to(PH_WAIT_BYTE);
    tick();
    send(mk(REQ_READ, 8'h11, 8'h22, 8'hFF, 8'h00, 1'b1));
    send(mk(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
    advance_to(PH_DAT_HI);
    send(mk(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0));
    send(mk(REQ_WRITE, 8'hFF, 8'hFF, 8'h80, 8'hFF, 1'b1));
    finish_bus();

    // Reads returning all ones then all zeros; the last byte of each is released.
    sda_fixed = 1;
    send(mk(REQ_READ, 8'h50, 8'h10, 8'h02, 8'h00, 1'b0));
    finish_bus();
    sda_fixed = 0;
    send(mk(REQ_READ, 8'hFE, 8'hFF, 8'h01, 8'h00, 1'b0));
    finish_bus();
    sda_fixed = -1;
    pause_until_drained();

    // Random part in four idling phases: none, sender idling, receiver stalling, and both.
    // Each phase ends with the sender holding off until every result has returned.
    for (int p = 0; p < 4; p++) begin
      idle_pct     = (p == 1) ? 69 : (p == 3) ? 34 : 0;
      stall_pct    = (p == 2) ? 69 : (p == 3) ? 34 : 0;
      useful_items = 0;
      while (useful_items < ITEMS_PER_PHASE) random_item();
      pause_until_drained();
    end
    idle_pct  = 0;
    stall_pct = 0;
    finish_bus();

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/i2cra_pkg.sv
hw/rtl/i2cra_if.sv
hw/rtl/i2c_master_register_access_core.sv
tb/sv/i2cra_sequence_model_pkg.sv
tb/sv/tb_top.sv
